// ===== sv/ahfcc_pkg.sv =====
// shared types, constants and decode functions for the ascii hex frame crc checker
package ahfcc_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  BYTE3_BASE = 8'hF0;
  localparam logic [7:0]  BYTE_MAX   = 8'h99;
  localparam logic [15:0] POS_MAX    = 16'hFFFF;
  // length under 20 means a last position below 19
  localparam logic [15:0] POS_SHORT  = 16'd19;
  localparam logic [15:0] TAIL_DEPTH = 16'd4;
  // position of the byte 3 low digit, counted from the first released character
  localparam logic [15:0] BYTE3_LO_Q = 16'd8;
  localparam logic [7:0]  HEX_BAD    = 8'hFF;
  localparam logic [7:0]  DIGIT_MAX  = 8'd9;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] HEX_A_OFFSET = 8'h37;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_BRACKET = 3'd2,
    ST_DIGIT   = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef struct packed {
    logic        crc_match;
    logic [15:0] crc_value;
    status_t     frame_status;
  } ahfcc_result_t;

  // uppercase hex digit to 0..15, anything else to 0xff
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_A && c <= CH_F) begin
      v = c - HEX_A_OFFSET;
    end else begin
      v = HEX_BAD;
    end
    return v;
  endfunction

  // one byte of reflected crc-16, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/ahfcc_out_skid.sv =====
// two-entry output stage: result register plus skid register
module ahfcc_out_skid
  import ahfcc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ahfcc_result_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ahfcc_result_t out_data
);

  logic          full;
  logic          full_next;
  logic          out_valid_next;
  logic          load_out_in;
  logic          load_out_skid;
  logic          load_skid;
  ahfcc_result_t skid;

  assign in_ready = !full;

  always_comb begin
    full_next      = full;
    out_valid_next = out_valid;
    load_out_in    = 1'b0;
    load_out_skid  = 1'b0;
    load_skid      = 1'b0;
    if (out_valid && !out_ready) begin
      // output stalled, park a new transfer in the skid register
      if (in_valid && !full) begin
        load_skid = 1'b1;
        full_next = 1'b1;
      end
    end else if (full) begin
      load_out_skid  = 1'b1;
      full_next      = 1'b0;
      out_valid_next = 1'b1;
    end else begin
      load_out_in    = in_valid;
      out_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      full      <= full_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_skid) begin
      skid <= in_data;
    end
    if (load_out_in) begin
      out_data <= in_data;
    end else if (load_out_skid) begin
      out_data <= skid;
    end
  end

  a_full_has_out: assert property (@(posedge clk) disable iff (rst) full |-> out_valid)
    else $error("skid full without a valid output");
  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
      in_valid && in_ready && out_valid && !out_ready |=> full)
    else $error("transfer during stall not parked");
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
      full && out_ready |=> !full)
    else $error("skid not drained");

endmodule

// ===== sv/ascii_hex_frame_crc_check.sv =====
// top level: ascii hex frame decoder with crc-16 check and result stage
//
// Input stream: one ASCII character per transfer on s_tdata[7:0], s_tlast marks
// the closing bracket of a frame. Every character is handled as it is taken,
// so the block accepts a transfer on every clock while the result side flows.
// Characters pass through a four-deep delay line; released characters are
// decoded into bytes and folded into the crc accumulator through an
// eight-step shift network in the same cycle as the transfer.
// Output stream: one result per frame, issued for the transfer with s_tlast set.
// m_tdata carries status, computed crc and match flag from the result register,
// valid while m_tvalid is high.
// A result register plus a skid register part the two sides: characters keep
// flowing while one result waits; s_tready drops only while two results are
// held because the receiver stalls.
// Reset (rst, synchronous, active high) clears the frame state and the valid
// flags of both result registers; frame state also returns to start after every frame.
module ascii_hex_frame_crc_check
  import ahfcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // char_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] frame_status, [18:3] crc_value, [19] crc_match
);

  logic [15:0]   pos;
  logic [15:0]   pos_next;
  logic [15:0]   crc;
  logic [15:0]   crc_next;
  logic [3:0]    high_digit;
  logic [3:0]    high_digit_next;
  logic          open_seen;
  logic          open_seen_next;
  status_t       first_err;
  status_t       first_err_next;
  logic [7:0]    tail [4];
  logic          s_acc;
  logic          res_ready;
  ahfcc_result_t res;
  ahfcc_result_t res_out;

  // release path
  logic [15:0]   q;
  logic [7:0]    d;
  logic [7:0]    b;
  // frame end path
  logic [7:0]    h0;
  logic [7:0]    h1;
  logic [7:0]    h2;
  logic [7:0]    h3;
  logic [15:0]   lo;
  logic [7:0]    hi;
  logic [15:0]   rx;
  logic          open_ok;
  status_t       status;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = res_ready;

  always_comb begin
    pos_next        = pos;
    crc_next        = crc;
    high_digit_next = high_digit;
    open_seen_next  = open_seen;
    first_err_next  = first_err;
    q               = pos - TAIL_DEPTH;
    d               = hex_val(tail[0]);
    b               = {high_digit, 4'b0000} + d;
    if (q == BYTE3_LO_Q) begin
      b = BYTE3_BASE + d;
    end

    h0      = hex_val(tail[0]);
    h1      = hex_val(tail[1]);
    h2      = hex_val(tail[2]);
    h3      = hex_val(tail[3]);
    lo      = {4'b0000, h0, 4'b0000} + {8'h00, h1};
    hi      = {h2[3:0], 4'b0000} + h3;
    rx      = {hi, 8'h00} + lo;
    open_ok = (pos == 16'd0) ? (s_tdata == CH_OPEN) : open_seen;
    if (pos < POS_SHORT) begin
      status = ST_SHORT;
    end else if (!open_ok || s_tdata != CH_CLOSE) begin
      status = ST_BRACKET;
    end else begin
      status = first_err;
    end
    res.frame_status = status;
    res.crc_value    = crc;
    res.crc_match    = (status == ST_OK) && (rx == crc);

    if (s_acc) begin
      if (s_tlast) begin
        pos_next        = 16'd0;
        crc_next        = CRC_INIT;
        high_digit_next = 4'd0;
        open_seen_next  = 1'b0;
        first_err_next  = ST_OK;
      end else begin
        if (pos == 16'd0) begin
          open_seen_next = (s_tdata == CH_OPEN);
        end
        // the opening bracket itself is released at q zero and skipped
        if (pos >= TAIL_DEPTH && q != 16'd0) begin
          if (q[0]) begin
            high_digit_next = d[3:0];
          end else begin
            crc_next = crc_byte(crc, b);
            if (first_err == ST_OK) begin
              if (q == BYTE3_LO_Q) begin
                if (d > DIGIT_MAX) begin
                  first_err_next = ST_DIGIT;
                end
              end else if (b > BYTE_MAX) begin
                first_err_next = ST_RANGE;
              end
            end
          end
        end
        if (pos != POS_MAX) begin
          pos_next = pos + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 16'd0;
      crc        <= CRC_INIT;
      high_digit <= 4'd0;
      open_seen  <= 1'b0;
      first_err  <= ST_OK;
    end else begin
      pos        <= pos_next;
      crc        <= crc_next;
      high_digit <= high_digit_next;
      open_seen  <= open_seen_next;
      first_err  <= first_err_next;
    end
  end

  // character delay line, holds text until it is known to be data or crc
  always_ff @(posedge clk) begin
    if (s_acc && !s_tlast) begin
      tail[0] <= tail[1];
      tail[1] <= tail[2];
      tail[2] <= tail[3];
      tail[3] <= s_tdata;
    end
  end

  ahfcc_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_acc && s_tlast),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_out)
  );

  assign m_tdata = {4'b0000, res_out};

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
      s_acc && s_tlast |=> pos == 16'd0 && crc == CRC_INIT && first_err == ST_OK)
    else $error("frame state not cleared after closing character");
  a_pos_counts: assert property (@(posedge clk) disable iff (rst)
      s_acc && !s_tlast && pos != POS_MAX |=> pos == $past(pos) + 16'd1)
    else $error("character position did not advance");
  a_match_needs_ok: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tdata[19] |-> m_tdata[2:0] == ST_OK)
    else $error("crc match reported on a faulty frame");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
      $past(first_err) != ST_OK && !$past(rst) && !$past(s_acc && s_tlast)
      |-> first_err == $past(first_err))
    else $error("first byte error overwritten");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the ascii hex frame crc checker
`timescale 1ns / 100ps

module tb;
  import ahfcc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int MIN_FRAME_LEN = 20;

  // expected results and the frame state that produces them
  class frame_checker;
    logic [15:0]   crc_acc;
    logic [15:0]   char_pos;
    logic [7:0]    tail [4];
    logic [3:0]    hi_digit;
    bit            open_seen;
    status_t       first_fault;
    ahfcc_result_t pending_results[$];
    int unsigned   mismatch_count;

    function void clear_frame();
      crc_acc = 16'hFFFF;
      char_pos = 16'd0;
      hi_digit = 4'd0;
      open_seen = 1'b0;
      first_fault = ST_OK;
    endfunction

    function void reset_state();
      clear_frame();
      tail = '{default: 8'h00};
      pending_results.delete();
      mismatch_count = 0;
    endfunction

    function int unsigned digit_of(logic [7:0] c);
      int unsigned d;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_A && c <= CH_F) begin
        d = c - CH_A + 10;
      end else begin
        d = 255;
      end
      return d;
    endfunction

    function logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      logic        lsb;
      r = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        lsb = r[0];
        r = r >> 1;
        if (lsb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    // a character leaves the delay line and, on even nonzero positions, completes a byte
    function void release_char(int unsigned q, logic [7:0] c);
      int unsigned d;
      logic [7:0]  b;
      d = digit_of(c);
      if (q != 0) begin
        if (q % 2 == 1) begin
          hi_digit = d[3:0];
        end else begin
          if ((q - 2) / 2 == 3) begin
            b = 8'hF0 + d[7:0];
            if (d > 9 && first_fault == ST_OK) first_fault = ST_DIGIT;
          end else begin
            b = {hi_digit, 4'h0} + d[7:0];
            if (b > 8'h99 && first_fault == ST_OK) first_fault = ST_RANGE;
          end
          crc_acc = crc_fold(crc_acc, b);
        end
      end
    endfunction

    function void take_char(logic [7:0] c, bit last);
      int unsigned   hi;
      int unsigned   lo;
      logic [15:0]   rx;
      bit            open_ok;
      status_t       st;
      ahfcc_result_t r;
      if (!last) begin
        if (char_pos == 0) open_seen = (c == CH_OPEN);
        if (char_pos >= 4) release_char(char_pos - 4, tail[0]);
        tail[0] = tail[1];
        tail[1] = tail[2];
        tail[2] = tail[3];
        tail[3] = c;
        if (char_pos != 16'hFFFF) char_pos = char_pos + 16'd1;
      end else begin
        hi = (digit_of(tail[2]) * 16 + digit_of(tail[3])) & 32'hFF;
        lo = digit_of(tail[0]) * 16 + digit_of(tail[1]);
        rx = 16'((hi << 8) + lo);
        open_ok = (char_pos == 0) ? (c == CH_OPEN) : open_seen;
        if (int'(char_pos) + 1 < MIN_FRAME_LEN) st = ST_SHORT;
        else if (!open_ok || c != CH_CLOSE) st = ST_BRACKET;
        else st = first_fault;
        r.frame_status = st;
        r.crc_value = crc_acc;
        r.crc_match = (st == ST_OK && rx == crc_acc);
        pending_results = {pending_results, r};
        clear_frame();
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_result(logic [23:0] data);
      ahfcc_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with none expected", data));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (data[2:0] != want.frame_status)
          report_mismatch($sformatf("frame_status %0d, expected %0d",
                                    data[2:0], want.frame_status));
        if (data[18:3] != want.crc_value)
          report_mismatch($sformatf("crc_value %h, expected %h", data[18:3], want.crc_value));
        if (data[19] != want.crc_match)
          report_mismatch($sformatf("crc_match %0b, expected %0b", data[19], want.crc_match));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  frame_checker sb = new;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_ask = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          sent_chars = 0;
  logic [7:0]  frame_buf[$];
  logic [7:0]  byte_plan[$];

  ascii_hex_frame_crc_check dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // transfer monitors and watchdog
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.take_char(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + {4'h0, v} : CH_A + {4'h0, v} - 8'd10;
  endfunction

  // well-formed frame of n bytes; planned bytes come first, the rest are random
  function automatic void build_frame(int n, bit good_crc);
    logic [15:0] crc;
    logic [7:0]  b;
    frame_buf.delete();
    frame_buf = {frame_buf, CH_OPEN};
    crc = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      if (i < byte_plan.size()) b = byte_plan[i];
      else if (i == 3) b = 8'hF0 + 8'($urandom_range(0, 9));
      else b = 8'($urandom_range(0, 8'h99));
      frame_buf = {frame_buf, hex_char(b[7:4])};
      frame_buf = {frame_buf, hex_char(b[3:0])};
      crc = sb.crc_fold(crc, b);
    end
    if (!good_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame_buf = {frame_buf, hex_char(crc[7:4])};
    frame_buf = {frame_buf, hex_char(crc[3:0])};
    frame_buf = {frame_buf, hex_char(crc[15:12])};
    frame_buf = {frame_buf, hex_char(crc[11:8])};
    frame_buf = {frame_buf, CH_CLOSE};
    byte_plan.delete();
  endfunction

  task automatic send_char(logic [7:0] c, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_buf.size(); k++) begin
      send_char(frame_buf[k], k == frame_buf.size() - 1);
    end
    sent_chars += frame_buf.size();
  endtask

  task automatic send_random_frame();
    int kind;
    int n;
    int cut;
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(7, 12);
    build_frame(n, $urandom_range(0, 99) < 85);
    if (kind < 60) begin
    end else if (kind < 68) begin
      frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 74) begin
      repeat ($urandom_range(2, 6))
        frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 78) begin
      frame_buf[0] = 8'($urandom_range(0, 255));
    end else if (kind < 82) begin
      frame_buf[frame_buf.size() - 1] = 8'($urandom_range(0, 255));
    end else if (kind < 86) begin
      // byte 3 low digit, mostly outside the decimal range
      frame_buf[8] = ($urandom_range(0, 1) == 0) ? hex_char(4'($urandom_range(10, 15)))
                                                 : 8'($urandom_range(0, 255));
    end else if (kind < 90) begin
      frame_buf[2 * $urandom_range(0, n - 1) + 1] = hex_char(4'($urandom_range(10, 15)));
    end else if (kind < 94) begin
      cut = $urandom_range(1, 19);
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    end else if (kind < 97) begin
      // odd leftover character ahead of the crc text
      frame_buf.insert(frame_buf.size() - 5, hex_char(4'($urandom_range(0, 15))));
    end else begin
      frame_buf.delete();
      repeat ($urandom_range(1, 45)) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    end
    send_frame();
  endtask

  initial begin
    int phase_chars;
    int phase_frames;
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shortest good frame, then a crc mismatch
    build_frame(7, 1'b1);
    send_frame();
    build_frame(7, 1'b0);
    send_frame();
    // field extremes; byte 3 first digit is ignored so the crc still matches
    byte_plan = {8'h99, 8'h00, 8'h55, 8'hF9, 8'h12, 8'h34, 8'h56, 8'h78};
    build_frame(8, 1'b1);
    frame_buf[7] = "7";
    send_frame();
    byte_plan = {8'h00, 8'h99, 8'h00, 8'hF0, 8'h99, 8'h00, 8'h99};
    build_frame(7, 1'b1);
    send_frame();
    // byte 3 digit faults
    byte_plan = {8'h11, 8'h22, 8'h33, 8'hFA};
    build_frame(7, 1'b1);
    send_frame();
    build_frame(7, 1'b1);
    frame_buf[8] = "G";
    send_frame();
    // range faults and their order against the byte 3 fault
    byte_plan = {8'h9A, 8'h00, 8'h00, 8'hF1, 8'h00, 8'h00, 8'hFF};
    build_frame(7, 1'b1);
    send_frame();
    byte_plan = {8'h10, 8'hA0, 8'h10, 8'hFB};
    build_frame(7, 1'b1);
    send_frame();
    byte_plan = {8'h10, 8'h20, 8'h30, 8'hFC, 8'h40, 8'hFF};
    build_frame(7, 1'b1);
    send_frame();
    // length 19, then single-character frames
    build_frame(7, 1'b1);
    frame_buf.delete(5);
    send_frame();
    frame_buf = {CH_OPEN};
    send_frame();
    frame_buf = {CH_CLOSE};
    send_frame();
    // a short frame wins over bad brackets, then bad opening and closing brackets
    frame_buf.delete();
    repeat (10) frame_buf = {frame_buf, 8'h58};
    send_frame();
    build_frame(7, 1'b1);
    frame_buf[0] = "(";
    send_frame();
    build_frame(7, 1'b1);
    frame_buf[frame_buf.size() - 1] = CH_OPEN;
    send_frame();
    // bracket fault wins over a range fault
    byte_plan = {8'hFF};
    build_frame(7, 1'b1);
    frame_buf[0] = " ";
    send_frame();
    // odd leftover high digit is dropped
    build_frame(8, 1'b1);
    frame_buf.insert(17, "5");
    send_frame();
    // lowercase digit, NUL, non-hex crc text, all-ones characters
    build_frame(7, 1'b1);
    frame_buf[1] = "a";
    send_frame();
    build_frame(7, 1'b1);
    frame_buf[2] = 8'h00;
    send_frame();
    build_frame(7, 1'b1);
    frame_buf[frame_buf.size() - 3] = 8'hFF;
    send_frame();
    frame_buf.delete();
    repeat (30) frame_buf = {frame_buf, 8'hFF};
    send_frame();
    build_frame(7, 1'b1);
    send_frame();

    // receiver holds off while frames keep coming, so the input side backs up
    hold_ask++;
    repeat (3) begin
      build_frame(7, 1'b1);
      send_frame();
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      phase_chars = sent_chars;
      phase_frames = 0;
      while (sent_chars - phase_chars < 60 || phase_frames < 2) begin
        send_random_frame();
        phase_frames++;
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
